[rtl/umcp_pkg.sv]
// umcp_pkg: shared constants and item types for the uart motion command parser
// no dependencies
`default_nettype none

package umcp_pkg;

  localparam int FRAME_BYTES    = 11;
  localparam int FC_W           = $clog2(FRAME_BYTES);
  localparam int IDLE_LIMIT_DEF = 10;
  localparam int IDLE_W         = 4;
  localparam int RESET_LEN      = 5;
  localparam int RC_W           = $clog2(RESET_LEN);
  localparam int LOG_LEN        = 4;
  localparam int LC_W           = $clog2(LOG_LEN);
  localparam int QUEUE_DEPTH    = 2;
  localparam int QPTR_W         = $clog2(QUEUE_DEPTH);

  localparam int TYPE_POS = 1;
  localparam int CTL_POS  = 2;
  localparam int VEL_POS  = 3;
  localparam int BCC_POS  = FRAME_BYTES - 2;
  localparam int TAIL_POS = FRAME_BYTES - 1;
  localparam int SEC_BIT  = 0;
  localparam int STOP_BIT = 7;

  localparam logic [7:0] HEAD_BYTE = 8'h7B;
  localparam logic [7:0] TAIL_BYTE = 8'h7D;
  localparam logic [7:0] CHR_LR    = 8'h72;
  localparam logic [7:0] CHR_LE    = 8'h65;
  localparam logic [7:0] CHR_LS    = 8'h73;
  localparam logic [7:0] CHR_LT    = 8'h74;
  localparam logic [7:0] CHR_UL    = 8'h4C;
  localparam logic [7:0] CHR_UO    = 8'h4F;
  localparam logic [7:0] CHR_UG    = 8'h47;
  localparam logic [7:0] CHR_D0    = 8'h30;
  localparam logic [7:0] CHR_D3    = 8'h33;

  typedef struct packed {
    logic               reset_request;
    logic               debug_valid;
    logic [1:0]         debug_level;
    logic               frame_ok;
    logic               rc_override;
    logic               stop;
    logic               sec;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] yaw_rate;
  } umcp_item_t;

  typedef struct packed {
    logic               cmd_valid;
    logic               zero_cmd_first;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] yaw_rate;
    logic               stop_flag;
    logic               params_valid;
    logic               security_level;
    logic               software_enable;
    logic               reset_request;
    logic               debug_valid;
    logic [1:0]         debug_level;
  } umcp_result_t;

endpackage

`default_nettype wire

[rtl/umcp_fifo.sv]
// umcp_fifo: short queue of classified items between front and back
// depends on umcp_pkg
`default_nettype none

module umcp_fifo (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire umcp_pkg::umcp_item_t wr_item,
  input  wire logic                pop,
  output umcp_pkg::umcp_item_t     rd_item,
  output logic                     empty,
  output logic                     full
);
  import umcp_pkg::*;

  umcp_item_t        mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;

  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign rd_item = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

`default_nettype wire

[rtl/umcp_front.sv]
// umcp_front: word scanners, frame assembly and running xor check per byte
// depends on umcp_pkg
`default_nettype none

module umcp_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             accept,
  input  wire logic [7:0]       rx_byte,
  input  wire logic             rc_override,
  output umcp_pkg::umcp_item_t  item
);
  import umcp_pkg::*;

  logic [FC_W-1:0] fc_r, fc_nxt;
  logic [RC_W-1:0] rc_r, rc_nxt;
  logic [LC_W-1:0] lc_r, lc_nxt;
  logic [7:0]      hist_r [3];
  logic [7:0]      xor_r, xor_nxt;
  logic [7:0]      type_r, ctl_r;
  logic [47:0]     vel_r;
  logic            bcc_ok_r;
  logic            reset_hit, log_hit, digit_ok;

  always_comb begin
    if (rc_r == RC_W'(RESET_LEN - 1)) begin
      rc_nxt = '0;
    end else if (rx_byte == CHR_LR || rc_r != '0) begin
      rc_nxt = rc_r + 1'b1;
    end else begin
      rc_nxt = '0;
    end
    if (lc_r == LC_W'(LOG_LEN - 1)) begin
      lc_nxt = '0;
    end else if (rx_byte == CHR_UL || lc_r != '0) begin
      lc_nxt = lc_r + 1'b1;
    end else begin
      lc_nxt = '0;
    end
    if (fc_r == FC_W'(TAIL_POS)) begin
      fc_nxt = '0;
    end else if (rx_byte == HEAD_BYTE || fc_r != '0) begin
      fc_nxt = fc_r + 1'b1;
    end else begin
      fc_nxt = '0;
    end
    xor_nxt = (fc_r == '0) ? rx_byte : (xor_r ^ rx_byte);
  end

  always_comb begin
    reset_hit = (rc_r == RC_W'(RESET_LEN - 1)) && hist_r[2] == CHR_LE &&
                hist_r[1] == CHR_LS && hist_r[0] == CHR_LE && rx_byte == CHR_LT;
    log_hit   = (lc_r == LC_W'(LOG_LEN - 1)) && hist_r[1] == CHR_UO && hist_r[0] == CHR_UG;
    digit_ok  = (rx_byte >= CHR_D0) && (rx_byte <= CHR_D3);

    item               = '0;
    item.reset_request = reset_hit;
    item.debug_valid   = log_hit;
    item.debug_level   = (log_hit && digit_ok) ? rx_byte[1:0] : 2'd0;
    item.frame_ok      = (fc_r == FC_W'(TAIL_POS)) && bcc_ok_r &&
                         rx_byte == TAIL_BYTE && type_r == 8'h00;
    item.rc_override   = rc_override;
    item.stop          = ctl_r[STOP_BIT];
    item.sec           = ctl_r[SEC_BIT];
    item.vel_x         = vel_r[47:32];
    item.vel_y         = vel_r[31:16];
    item.yaw_rate      = vel_r[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fc_r <= '0;
      rc_r <= '0;
      lc_r <= '0;
    end else if (accept) begin
      fc_r <= fc_nxt;
      rc_r <= rc_nxt;
      lc_r <= lc_nxt;
    end
  end

  // frame and history bytes
  always_ff @(posedge clk) begin
    if (accept) begin
      hist_r[0] <= rx_byte;
      hist_r[1] <= hist_r[0];
      hist_r[2] <= hist_r[1];
      if (fc_r < FC_W'(BCC_POS)) begin
        xor_r <= xor_nxt;
      end
      if (fc_r == FC_W'(TYPE_POS)) begin
        type_r <= rx_byte;
      end
      if (fc_r == FC_W'(CTL_POS)) begin
        ctl_r <= rx_byte;
      end
      if (fc_r >= FC_W'(VEL_POS) && fc_r < FC_W'(BCC_POS)) begin
        vel_r <= {vel_r[39:0], rx_byte};
      end
      if (fc_r == FC_W'(BCC_POS)) begin
        bcc_ok_r <= (rx_byte == xor_r);
      end
    end
  end

endmodule

`default_nettype wire

[rtl/umcp_back.sv]
// umcp_back: idle and override gating of accepted frames, result register
// depends on umcp_pkg
`default_nettype none

module umcp_back #(
  parameter int IDLE_LIMIT = umcp_pkg::IDLE_LIMIT_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire umcp_pkg::umcp_item_t head,
  input  wire logic                 head_valid,
  output logic                      pop,
  input  wire logic                 out_stall,
  output logic                      out_valid,
  output umcp_pkg::umcp_result_t    result
);
  import umcp_pkg::*;

  logic [IDLE_W-1:0] idle_r, idle_nxt;
  logic              blk_r, blk_nxt;
  logic              out_valid_r;
  umcp_result_t      res_r, res_nxt;
  logic              zero, allow;

  assign pop       = head_valid && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign result    = res_r;

  always_comb begin
    zero     = (head.vel_x == '0) && (head.vel_y == '0) && (head.yaw_rate == '0);
    idle_nxt = idle_r;
    blk_nxt  = blk_r;
    allow    = 1'b1;
    res_nxt  = '0;
    res_nxt.reset_request = head.reset_request;
    res_nxt.debug_valid   = head.debug_valid;
    res_nxt.debug_level   = head.debug_level;
    if (head.frame_ok) begin
      res_nxt.params_valid    = 1'b1;
      res_nxt.security_level  = head.sec;
      res_nxt.software_enable = head.stop;
      if (zero) begin
        if (idle_r < IDLE_W'(IDLE_LIMIT)) begin
          idle_nxt = idle_r + 1'b1;
        end
      end else begin
        idle_nxt = '0;
      end
      if (head.rc_override) begin
        res_nxt.zero_cmd_first = !blk_r;
        blk_nxt                = 1'b1;
        allow                  = zero || head.stop;
      end else begin
        blk_nxt = 1'b0;
      end
      if (allow && (idle_nxt < IDLE_W'(IDLE_LIMIT) || zero || head.stop)) begin
        res_nxt.cmd_valid = 1'b1;
        res_nxt.vel_x     = head.vel_x;
        res_nxt.vel_y     = head.vel_y;
        res_nxt.yaw_rate  = head.yaw_rate;
        res_nxt.stop_flag = head.stop;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_r      <= '0;
      blk_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        idle_r      <= idle_nxt;
        blk_r       <= blk_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_r <= res_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/uart_motion_command_parser.sv]
// uart_motion_command_parser: one uart byte in, one result item out per byte
// an accepted byte's item is written into the queue, then popped into the result register when nothing stalls
// throughput: one item per cycle while out_stall is low, set by the front and back stages
// a two-entry queue between front and back absorbs output stalls
// reset: synchronous active-low rst_n clears scanners, counters, gating state and queue
// depends on umcp_pkg, umcp_front, umcp_fifo, umcp_back
`default_nettype none

module uart_motion_command_parser #(
  parameter int IDLE_LIMIT = umcp_pkg::IDLE_LIMIT_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [7:0]         in_rx_byte,
  input  wire logic               in_rc_override,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    out_cmd_valid,
  output logic                    out_zero_cmd_first,
  output logic signed [15:0]      out_vel_x,
  output logic signed [15:0]      out_vel_y,
  output logic signed [15:0]      out_yaw_rate,
  output logic                    out_stop_flag,
  output logic                    out_params_valid,
  output logic                    out_security_level,
  output logic                    out_software_enable,
  output logic                    out_reset_request,
  output logic                    out_debug_valid,
  output logic [1:0]              out_debug_level
);
  import umcp_pkg::*;

  logic         accept, q_full, q_empty, q_pop;
  umcp_item_t   front_item, head_item;
  umcp_result_t res;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  umcp_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .rx_byte     (in_rx_byte),
    .rc_override (in_rc_override),
    .item        (front_item)
  );

  umcp_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (accept),
    .wr_item (front_item),
    .pop     (q_pop),
    .rd_item (head_item),
    .empty   (q_empty),
    .full    (q_full)
  );

  umcp_back #(
    .IDLE_LIMIT (IDLE_LIMIT)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head_item),
    .head_valid (!q_empty),
    .pop        (q_pop),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .result     (res)
  );

  assign out_cmd_valid       = res.cmd_valid;
  assign out_zero_cmd_first  = res.zero_cmd_first;
  assign out_vel_x           = res.vel_x;
  assign out_vel_y           = res.vel_y;
  assign out_yaw_rate        = res.yaw_rate;
  assign out_stop_flag       = res.stop_flag;
  assign out_params_valid    = res.params_valid;
  assign out_security_level  = res.security_level;
  assign out_software_enable = res.software_enable;
  assign out_reset_request   = res.reset_request;
  assign out_debug_valid     = res.debug_valid;
  assign out_debug_level     = res.debug_level;

`ifndef SYNTHESIS
  a_cmd_needs_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_cmd_valid |-> out_params_valid)
    else $error("command without accepted frame");

  a_zero_first_needs_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_cmd_first |-> out_params_valid)
    else $error("zero command without accepted frame");

  a_vel_only_with_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_cmd_valid |->
      (out_vel_x == 16'sd0 && out_vel_y == 16'sd0 && out_yaw_rate == 16'sd0 && !out_stop_flag))
    else $error("velocity without command");

  a_level_only_with_log: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_debug_valid |-> out_debug_level == 2'd0)
    else $error("debug level without log word");
`endif

endmodule

`default_nettype wire
